@@ src/pixel_gamma_contrast_brightness_top_defines.svh @@
// assertion macros for the pixel gamma/contrast/brightness block
// used by the checker; expects clk and rst_n in the including scope
`ifndef PIXEL_GAMMA_CONTRAST_BRIGHTNESS_TOP_DEFINES_SVH
`define PIXEL_GAMMA_CONTRAST_BRIGHTNESS_TOP_DEFINES_SVH

// property checked out of reset
`define PGCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define PGCB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pgcb_pkg.sv @@
// shared types, constants and elaboration-time functions of the pixel adjust block
// no dependencies
package pgcb_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_GAMMA      = 3'd0;
  localparam logic [2:0] CFG_CONTRAST   = 3'd1;
  localparam logic [2:0] CFG_BRIGHTNESS = 3'd2;
  localparam logic [2:0] CFG_COLOUR     = 3'd3;
  localparam logic [2:0] CFG_LUMA       = 3'd4;

  // one in Q30
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // stages of one adjust lane: input, 16 log, diff, scale, 16 exp, pow, gain, clamp
  localparam int LANE_LAT = 38;

  // per-channel control into the output stage
  typedef struct packed {
    logic luma;   // rescale by the adjusted max channel
    logic kill;   // channel forced to zero (grey mode)
  } pgcb_ctl_t;

  // floor integer square root
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = x;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q30, k = 1..16
  function automatic logic [30:0] exp_coef(input int k);
    logic [63:0] t;
    t = isqrt64(64'd1 << 59);
    for (int j = 2; j <= 16; j++) begin
      if (j <= k) t = isqrt64(t << 30);
    end
    return t[30:0];
  endfunction

  // log2 in Q16 of a constant 1..65535, same squaring scheme as the lanes
  function automatic logic [19:0] log2_q16(input logic [15:0] p);
    logic [3:0]  e;
    logic [63:0] n;
    logic [15:0] fr;
    e = '0;
    for (int i = 1; i < 16; i++) begin
      if (p[i]) e = 4'(i);
    end
    n  = 64'(p) << (4'd15 - e);
    fr = '0;
    for (int i = 0; i < 16; i++) begin
      n  = (n * n) >> 15;
      fr = {fr[14:0], (n >= 64'd65536)};
      if (n >= 64'd65536) n = n >> 1;
    end
    return {e, fr};
  endfunction

endpackage

@@ src/pgcb_in_if.sv @@
// input pixel channel: valid/ready handshake with the three input bytes
// no dependencies
interface pgcb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_blue;
  logic [7:0] chan_green;
  logic [7:0] chan_red;

  modport source (output valid, output chan_blue, output chan_green, output chan_red,
                  input ready);
  modport sink (input valid, input chan_blue, input chan_green, input chan_red,
                output ready);
endinterface

@@ src/pgcb_out_if.sv @@
// result pixel channel: valid/ready handshake with the three adjusted bytes
// no dependencies
interface pgcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] res_blue;
  logic [7:0] res_green;
  logic [7:0] res_red;

  modport source (output valid, output res_blue, output res_green, output res_red,
                  input ready);
  modport sink (input valid, input res_blue, input res_green, input res_red,
                output ready);
endinterface

@@ src/pgcb_delay.sv @@
// shift line that carries side data alongside the adjust lanes
// depends on nothing but clk and the pipeline advance
module pgcb_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // first tap
  always_ff @(posedge clk) begin
    if (adv) tap_r[0] <= din;
  end

  // remaining taps
  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (adv) tap_r[k] <= tap_r[k-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

@@ src/pgcb_lane.sv @@
// one adjust lane: log2, gamma scale, exp2, gain/offset and clamp, LANE_LAT stages
// depends on pgcb_pkg
module pgcb_lane
  import pgcb_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [PIXEL_BITS-1:0] p,
  input  logic [15:0]           gamma_q12,
  input  logic signed [15:0]    contrast_q12,
  input  logic signed [15:0]    brightness_q12,
  output logic [30:0]           y30
);

  localparam logic [15:0] PIX_MAX = 16'((1 << PIXEL_BITS) - 1);
  localparam logic [19:0] LOG_MAX = log2_q16(PIX_MAX);

  // log stage registers
  logic [15:0] ln_r [17];
  logic [15:0] lf_r [17];
  logic [3:0]  le_r [17];
  logic        lz_r [17];

  // exp stage registers
  logic [30:0] er_r [17];
  logic [23:0] ea_r [17];
  logic        ez_r [17];

  logic [3:0]  e_c;
  logic [15:0] n0_c;
  logic [19:0] lp_c;
  logic [19:0] d_r;
  logic        dz_r;
  logic [35:0] a_c;
  logic [7:0]  ip_c;
  logic [30:0] pow_r;
  logic signed [48:0] s_c;
  logic signed [48:0] s_r;
  logic [30:0] y_r;

  // msb search and mantissa normalization
  always_comb begin
    e_c = '0;
    for (int i = 1; i < PIXEL_BITS; i++) begin
      if (p[i]) e_c = 4'(i);
    end
    n0_c = 16'(32'(p) << (4'd15 - e_c));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ln_r[0] <= n0_c;
      lf_r[0] <= '0;
      le_r[0] <= e_c;
      lz_r[0] <= (p == '0);
    end
  end

  // one fraction bit per squaring stage
  for (genvar k = 0; k < 16; k++) begin : g_log
    logic [31:0] sq_c;
    logic [16:0] sh_c;
    assign sq_c = 32'(ln_r[k]) * 32'(ln_r[k]);
    assign sh_c = sq_c[31:15];
    always_ff @(posedge clk) begin
      if (adv) begin
        ln_r[k+1] <= sh_c[16] ? sh_c[16:1] : sh_c[15:0];
        lf_r[k+1] <= {lf_r[k][14:0], sh_c[16]};
        le_r[k+1] <= le_r[k];
        lz_r[k+1] <= lz_r[k];
      end
    end
  end

  // distance below full scale, clamped at zero
  assign lp_c = {le_r[16], lf_r[16]};

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r  <= (LOG_MAX > lp_c) ? LOG_MAX - lp_c : '0;
      dz_r <= lz_r[16];
    end
  end

  // exponent scaled by gamma
  assign a_c = 36'(gamma_q12) * 36'(d_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      er_r[0] <= ONE_Q30;
      ea_r[0] <= a_c[35:12];
      ez_r[0] <= dz_r;
    end
  end

  // exp2 of the fraction, one coefficient per stage, msb first
  for (genvar k = 0; k < 16; k++) begin : g_exp
    localparam logic [30:0] COEF = exp_coef(k + 1);
    logic [61:0] pr_c;
    assign pr_c = 62'(er_r[k]) * 62'(COEF);
    always_ff @(posedge clk) begin
      if (adv) begin
        er_r[k+1] <= ea_r[k][15-k] ? pr_c[60:30] : er_r[k];
        ea_r[k+1] <= ea_r[k];
        ez_r[k+1] <= ez_r[k];
      end
    end
  end

  // integer part of the exponent, zero input special case
  assign ip_c = ea_r[16][23:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ez_r[16]) begin
        pow_r <= (gamma_q12 == '0) ? ONE_Q30 : '0;
      end else if (ip_c >= 8'd31) begin
        pow_r <= '0;
      end else begin
        pow_r <= er_r[16] >> ip_c[4:0];
      end
    end
  end

  // gain and offset in Q42
  assign s_c = 49'(contrast_q12) * 49'($signed({1'b0, pow_r}))
             + (49'(brightness_q12) <<< 30);

  always_ff @(posedge clk) begin
    if (adv) s_r <= s_c;
  end

  // clamp to [0, 1] and drop to Q30
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s_r <= 49'sd0) begin
        y_r <= '0;
      end else if (s_r >= (49'sd1 <<< 42)) begin
        y_r <= ONE_Q30;
      end else begin
        y_r <= s_r[42:12];
      end
    end
  end

  assign y30 = y_r;

endmodule

@@ src/pgcb_out.sv @@
// output stage of one channel: rounding to a pixel, or luma rescale by a pipelined divider
// depends on pgcb_pkg; registered through a rounding stage, a numerator stage, the divider and an output register
module pgcb_out
  import pgcb_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [30:0]           y30,
  input  logic [PIXEL_BITS-1:0] c,
  input  logic [PIXEL_BITS-1:0] v,
  input  pgcb_ctl_t             ctl,
  output logic [7:0]            res
);

  localparam int PB    = PIXEL_BITS;
  localparam int NUM_W = 2 * PB + 31;
  localparam int PRD_W = PB + 32;
  localparam logic [PB-1:0] PIX_MAX = {PB{1'b1}};

  logic [PRD_W-1:0] rnd_c;
  logic [PB-1:0]    pix0_r;
  logic [2*PB-1:0]  cm_r;
  logic [30:0]      y0_r;
  logic [PB-1:0]    v0_r;
  pgcb_ctl_t        ctl0_r;

  logic [NUM_W-1:0] rem_r [PB+1];
  logic [PB-1:0]    q_r   [PB+1];
  logic [PB-1:0]    pix_r [PB+1];
  logic [PB-1:0]    v_r   [PB+1];
  pgcb_ctl_t        ctl_r [PB+1];
  logic [PB-1:0]    sel_c;
  logic [7:0]       res_r;

  // round half up to a pixel, and c * max for the rescale
  assign rnd_c = PRD_W'(y30) * PRD_W'(PIX_MAX) + (PRD_W'(1) << 29);

  always_ff @(posedge clk) begin
    if (adv) begin
      pix0_r <= rnd_c[PB+29:30];
      cm_r   <= (2*PB)'(c) * (2*PB)'(PIX_MAX);
      y0_r   <= y30;
      v0_r   <= v;
      ctl0_r <= ctl;
    end
  end

  // rescale numerator with half a divisor added for rounding
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= NUM_W'(cm_r) * NUM_W'(y0_r) + (NUM_W'(v0_r) << 29);
      q_r[0]   <= '0;
      pix_r[0] <= pix0_r;
      v_r[0]   <= v0_r;
      ctl_r[0] <= ctl0_r;
    end
  end

  // restoring divide by v * 2^30, one quotient bit per stage
  for (genvar j = 0; j < PB; j++) begin : g_div
    logic [NUM_W-1:0] dsh_c;
    logic             ge_c;
    assign dsh_c = NUM_W'(v_r[j]) << (30 + PB - 1 - j);
    assign ge_c  = (rem_r[j] >= dsh_c);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1] <= ge_c ? rem_r[j] - dsh_c : rem_r[j];
        q_r[j+1]   <= {q_r[j][PB-2:0], ge_c};
        pix_r[j+1] <= pix_r[j];
        v_r[j+1]   <= v_r[j];
        ctl_r[j+1] <= ctl_r[j];
      end
    end
  end

  // pick the rescaled value in luma mode unless the pixel is black
  assign sel_c = (ctl_r[PB].luma && (v_r[PB] != '0)) ? q_r[PB] : pix_r[PB];

  always_ff @(posedge clk) begin
    if (adv) res_r <= ctl_r[PB].kill ? 8'd0 : sel_c[7:0];
  end

  assign res = res_r;

endmodule

@@ src/pixel_gamma_contrast_brightness_top.sv @@
// top level of the pixel gamma/contrast/brightness block: config registers,
// valid line, three adjust lanes and three output stages; depends on pgcb_pkg and the interfaces
//
//   port      dir   width  role
//   in_px     sink  3x8    pixel in (blue is grey)
//   out_px    src   3x8    adjusted pixel
//   cfg_*     in    1/3/16 register write
//
// one pixel per clock while the output is not stalled; the data passes through
// the 16-stage log and 16-stage exp chains plus the bit-per-stage divider
// all stages move together on one advance; a stalled output freezes the whole pipe
// synchronous active-low reset clears the valid line and loads register defaults
module pixel_gamma_contrast_brightness_top
  import pgcb_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  pgcb_in_if.sink           in_px,
  pgcb_out_if.source        out_px,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [15:0]       cfg_wdata
);

  localparam int PB  = PIXEL_BITS;
  localparam int LAT = LANE_LAT + PB + 3;

  logic [15:0]        gamma_r;
  logic signed [15:0] contrast_r;
  logic signed [15:0] brightness_r;
  logic               colour_r;
  logic               luma_r;

  logic [LAT-1:0]     vld_r;
  logic               adv;
  logic               luma_mode;

  logic [PB-1:0]      c_in [3];
  logic [PB-1:0]      v_in;
  logic [PB-1:0]      lane_p [3];
  logic [30:0]        lane_y [3];
  logic [4*PB-1:0]    side_d;
  logic [PB-1:0]      c_d [3];
  logic [PB-1:0]      v_d;
  logic [7:0]         res [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r      <= 16'd4096;
      contrast_r   <= 16'sd4096;
      brightness_r <= '0;
      colour_r     <= 1'b1;
      luma_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAMMA:      gamma_r      <= cfg_wdata;
        CFG_CONTRAST:   contrast_r   <= cfg_wdata;
        CFG_BRIGHTNESS: brightness_r <= cfg_wdata;
        CFG_COLOUR:     colour_r     <= cfg_wdata[0];
        CFG_LUMA:       luma_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid line
  assign adv         = !vld_r[LAT-1] || out_px.ready;
  assign in_px.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_px.valid};
    end
  end

  assign luma_mode = colour_r && luma_r;

  // input widening and max channel
  assign c_in[0] = PB'(in_px.chan_blue);
  assign c_in[1] = PB'(in_px.chan_green);
  assign c_in[2] = PB'(in_px.chan_red);

  always_comb begin
    v_in = c_in[0];
    if (c_in[1] > v_in) v_in = c_in[1];
    if (c_in[2] > v_in) v_in = c_in[2];
  end

  // lane 0 takes the max channel in luma mode
  assign lane_p[0] = luma_mode ? v_in : c_in[0];
  assign lane_p[1] = c_in[1];
  assign lane_p[2] = c_in[2];

  // channel values ride alongside the lanes
  pgcb_delay #(.WIDTH(4 * PB), .DEPTH(LANE_LAT)) u_side (
    .clk  (clk),
    .adv  (adv),
    .din  ({v_in, c_in[2], c_in[1], c_in[0]}),
    .dout (side_d)
  );

  assign c_d[0] = side_d[PB-1:0];
  assign c_d[1] = side_d[2*PB-1:PB];
  assign c_d[2] = side_d[3*PB-1:2*PB];
  assign v_d    = side_d[4*PB-1:3*PB];

  for (genvar i = 0; i < 3; i++) begin : g_chan
    pgcb_ctl_t ctl;

    assign ctl.luma = luma_mode;
    assign ctl.kill = !colour_r && (i != 0);

    pgcb_lane #(.PIXEL_BITS(PB)) u_lane (
      .clk            (clk),
      .adv            (adv),
      .p              (lane_p[i]),
      .gamma_q12      (gamma_r),
      .contrast_q12   (contrast_r),
      .brightness_q12 (brightness_r),
      .y30            (lane_y[i])
    );

    pgcb_out #(.PIXEL_BITS(PB)) u_out (
      .clk (clk),
      .adv (adv),
      .y30 (luma_mode ? lane_y[0] : lane_y[i]),
      .c   (c_d[i]),
      .v   (v_d),
      .ctl (ctl),
      .res (res[i])
    );
  end

  // result channel
  assign out_px.valid     = vld_r[LAT-1];
  assign out_px.res_blue  = res[0];
  assign out_px.res_green = res[1];
  assign out_px.res_red   = res[2];

endmodule

@@ src/pgcb_checker.sv @@
// port-level checks of the pixel adjust block, bound to the top level
// depends on pixel_gamma_contrast_brightness_top_defines.svh
`include "pixel_gamma_contrast_brightness_top_defines.svh"

module pgcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_data
);

  // a waiting result keeps its transfer pending
  `PGCB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a waiting result keeps its payload
  `PGCB_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "stalled result changed")

  // input side only stalls when the output stalls
  `PGCB_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "input stall without output stall")

  // reset empties the pipe
  `PGCB_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind pixel_gamma_contrast_brightness_top pgcb_checker u_pgcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .out_data  ({out_px.res_red, out_px.res_green, out_px.res_blue})
);
